/* hdl/midi_polyphonic_pulse_generator_core_defines.svh */
// Assertion macros used by the checker file of the pulse generator core.
`ifndef MIDI_POLYPHONIC_PULSE_GENERATOR_CORE_DEFINES_SVH
`define MIDI_POLYPHONIC_PULSE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MPPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mppg check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MPPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mppg check failed");

`endif

/* hdl/mppg_pkg.sv */
// Types, constants and the note-to-period table of the pulse generator core.
`timescale 1ns / 1ps

package mppg_pkg;

    localparam int VOICES   = 4;
    localparam int IDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W    = $clog2(VOICES + 1);
    localparam int PERIOD_W = 11;
    localparam int COUNT_W  = 16;
    localparam int NOTE_COUNT = 256;

    // MIDI status codes (upper nibble or full byte)
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_PROG     = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [7:0] SB_TIME_CODE  = 8'hF1;
    localparam logic [7:0] SB_SONG_SEL   = 8'hF3;
    localparam logic [7:0] SB_TUNE_REQ   = 8'hF6;
    localparam logic [7:0] SB_CLOCK      = 8'hF8;
    localparam logic [7:0] SB_START      = 8'hFA;
    localparam logic [7:0] SB_CONTINUE   = 8'hFB;
    localparam logic [7:0] SB_STOP       = 8'hFC;
    localparam logic [7:0] SB_SENSE      = 8'hFE;
    localparam logic [7:0] SB_RESET      = 8'hFF;

    // Note folding and period table construction
    localparam int NOTE_MIN   = 12;
    localparam int NOTE_MAX   = 91;
    localparam int OCTAVE     = 12;
    localparam int FOLD_STEPS = 14;
    localparam int NOTE_TOP   = 85;
    localparam int TOP_BASE   = 106;
    localparam longint unsigned BASE_PERIOD = 22;
    localparam longint unsigned RATIO_NUM   = 1059463;
    localparam longint unsigned RATIO_DEN   = 1000000;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_NOTE_ON,
        OP_NOTE_OFF
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                active;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  count;
    } voice_t;

    typedef struct packed {
        op_t                 op;
        logic [PERIOD_W-1:0] period;
    } msg_t;

    typedef struct packed {
        logic                start;
        op_t                 op;
        logic [PERIOD_W-1:0] period;
    } eng_cmd_t;

    typedef struct packed {
        logic done;
        logic pin_level;
        logic lamp;
    } eng_status_t;

    typedef logic [NOTE_COUNT-1:0][PERIOD_W-1:0] period_rom_t;

    // Fold every byte into 12..91, then apply the fixed-point period formula.
    function automatic period_rom_t build_period_rom();
        period_rom_t     rom;
        longint unsigned v;
        int              n;
        rom = '0;
        for (int b = 0; b < NOTE_COUNT; b++)
        begin
            n = b;
            for (int k = 0; k < FOLD_STEPS; k++)
            begin
                if (n > NOTE_MAX)
                begin
                    n = n - OCTAVE;
                end
            end
            if (n < NOTE_MIN)
            begin
                n = n + OCTAVE;
            end
            if (n >= NOTE_TOP)
            begin
                rom[b] = PERIOD_W'(TOP_BASE - n);
            end
            else
            begin
                v = BASE_PERIOD << 32;
                for (int k = 0; k < NOTE_TOP - n; k++)
                begin
                    v = v * RATIO_NUM / RATIO_DEN;
                end
                rom[b] = PERIOD_W'(v >> 32);
            end
        end
        return rom;
    endfunction

    localparam period_rom_t NOTE_PERIOD = build_period_rom();

    // Message length in bytes, set by the first byte.
    function automatic logic [1:0] frame_len(input logic [7:0] first);
        logic [1:0] len;
        len = 2'd3;
        if (first[7:4] == HI_PROG || first[7:4] == HI_PRESSURE ||
            first == SB_TIME_CODE || first == SB_SONG_SEL)
        begin
            len = 2'd2;
        end
        else if (first == SB_TUNE_REQ || first == SB_CLOCK || first == SB_START ||
                 first == SB_CONTINUE || first == SB_STOP || first == SB_SENSE ||
                 first == SB_RESET)
        begin
            len = 2'd1;
        end
        return len;
    endfunction

endpackage

/* hdl/mppg_framer.sv */
// MIDI byte framer: collects message bytes and decodes note on and note off.
`timescale 1ns / 1ps

module mppg_framer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       midi_byte,
    output mppg_pkg::msg_t   msg
);

    logic [1:0] frame_pos_reg, frame_pos_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] note_reg, note_next;
    logic [1:0] pos_inc;
    logic       complete;

    always_comb
    begin
        status_next = (frame_pos_reg == 2'd0) ? midi_byte : status_reg;
        note_next   = (frame_pos_reg == 2'd1) ? midi_byte : note_reg;
        pos_inc     = frame_pos_reg + 2'd1;
        complete    = (pos_inc >= mppg_pkg::frame_len(status_next));
        frame_pos_next = complete ? 2'd0 : pos_inc;

        msg.op     = mppg_pkg::OP_NONE;
        msg.period = mppg_pkg::NOTE_PERIOD[note_next];
        if (complete)
        begin
            if (status_next[7:4] == mppg_pkg::HI_NOTE_ON && midi_byte != 8'd0)
            begin
                msg.op = mppg_pkg::OP_NOTE_ON;
            end
            else if (status_next[7:4] == mppg_pkg::HI_NOTE_ON ||
                     status_next[7:4] == mppg_pkg::HI_NOTE_OFF)
            begin
                msg.op = mppg_pkg::OP_NOTE_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= 2'd0;
            status_reg    <= 8'd0;
            note_reg      <= 8'd0;
        end
        else if (take)
        begin
            frame_pos_reg <= frame_pos_next;
            status_reg    <= status_next;
            note_reg      <= note_next;
        end
    end

endmodule

/* hdl/mppg_voice_engine.sv */
// Voice memory and the sweep that reads, updates and writes back every voice.
`timescale 1ns / 1ps

module mppg_voice_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mppg_pkg::eng_cmd_t     cmd,
    output mppg_pkg::eng_status_t  status
);

    mppg_pkg::voice_t voice_mem [mppg_pkg::VOICES];
    mppg_pkg::voice_t mem_rd_reg;

    logic [mppg_pkg::VOICES-1:0]   vld_reg;
    logic                          rd_vld_reg;
    logic                          running_reg;
    logic [mppg_pkg::CNT_W-1:0]    rd_cnt_reg;
    logic                          s1_vld_reg;
    logic [mppg_pkg::IDX_W-1:0]    s1_idx_reg;
    mppg_pkg::op_t                 op_reg;
    logic [mppg_pkg::PERIOD_W-1:0] period_reg;
    logic                          found_reg, found_next;
    logic                          pin_level_reg, pin_level_next;
    logic                          lamp_reg, lamp_next;

    logic                          rd_en;
    logic [mppg_pkg::IDX_W-1:0]    rd_idx;
    logic                          last;
    mppg_pkg::voice_t              entry;
    mppg_pkg::voice_t              wr_entry;
    logic [mppg_pkg::COUNT_W-1:0]  count_fix;
    logic [mppg_pkg::COUNT_W-1:0]  period_ext;

    assign rd_en  = running_reg && (rd_cnt_reg < mppg_pkg::CNT_W'(mppg_pkg::VOICES));
    assign rd_idx = rd_cnt_reg[mppg_pkg::IDX_W-1:0];
    assign last   = running_reg && s1_vld_reg && !rd_en;

    // Entries never written read as the reset value.
    assign entry      = rd_vld_reg ? mem_rd_reg : '0;
    assign period_ext = mppg_pkg::COUNT_W'(entry.period);

    always_comb
    begin
        wr_entry       = entry;
        pin_level_next = pin_level_reg;
        lamp_next      = lamp_reg;
        found_next     = found_reg;
        count_fix      = entry.count;
        unique case (op_reg)
            mppg_pkg::OP_TICK:
            begin
                if (entry.count == period_ext && entry.active)
                begin
                    pin_level_next = 1'b0;
                end
                if (entry.count == period_ext + mppg_pkg::COUNT_W'(1))
                begin
                    pin_level_next = 1'b1;
                    count_fix      = '0;
                end
                wr_entry.count = count_fix + mppg_pkg::COUNT_W'(1);
            end
            mppg_pkg::OP_NOTE_OFF:
            begin
                if (entry.period == period_reg)
                begin
                    wr_entry.active = 1'b0;
                    lamp_next       = 1'b0;
                end
            end
            mppg_pkg::OP_NOTE_ON:
            begin
                if (!entry.active && !found_reg)
                begin
                    wr_entry.active = 1'b1;
                    wr_entry.period = period_reg;
                    wr_entry.count  = '0;
                    lamp_next       = 1'b1;
                    found_next      = 1'b1;
                end
            end
            mppg_pkg::OP_NONE:
            begin
                wr_entry = entry;
            end
        endcase
    end

    // Memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            voice_mem[s1_idx_reg] <= wr_entry;
        end
        if (rd_en)
        begin
            mem_rd_reg <= voice_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            running_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s1_idx_reg    <= '0;
            op_reg        <= mppg_pkg::OP_NONE;
            period_reg    <= '0;
            found_reg     <= 1'b0;
            pin_level_reg <= 1'b1;
            lamp_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                running_reg <= 1'b1;
                rd_cnt_reg  <= '0;
                op_reg      <= cmd.op;
                period_reg  <= cmd.period;
                found_reg   <= 1'b0;
            end
            else if (last)
            begin
                running_reg <= 1'b0;
            end

            s1_vld_reg <= rd_en;
            if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + mppg_pkg::CNT_W'(1);
                s1_idx_reg <= rd_idx;
                rd_vld_reg <= vld_reg[rd_idx];
            end

            if (s1_vld_reg)
            begin
                vld_reg[s1_idx_reg] <= 1'b1;
                pin_level_reg       <= pin_level_next;
                lamp_reg            <= lamp_next;
                found_reg           <= found_next;
            end
        end
    end

    assign status.done      = last;
    assign status.pin_level = pin_level_reg;
    assign status.lamp      = lamp_reg;

endmodule

/* hdl/midi_polyphonic_pulse_generator_core.sv */
// Top level of the MIDI-driven polyphonic pulse generator (interrupter) core.
//
//   channel  | handshake           | word
//   ---------+---------------------+--------------------------------
//   in       | in_valid / in_stall | action, midi_byte
//   out      | out_valid/out_stall | out_level, led
//
// A tick or a note on/off reaches the result register after the sweep
// (one voice read per cycle, last write-back, load); other bytes go straight to the load.
// Input reopens in the cycle after the load.
// Reset clears framing, voice valid bits, pin (high) and lamp; no sweep.
// One word is in work at a time; a held result does not block acceptance
// of the next word, only the loading of the following result.
`timescale 1ns / 1ps

module midi_polyphonic_pulse_generator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_level,
    output logic       led
);

    mppg_pkg::state_t      state_reg, state_next;
    mppg_pkg::msg_t        msg;
    mppg_pkg::eng_cmd_t    cmd;
    mppg_pkg::eng_status_t status;
    mppg_pkg::op_t         op;

    logic in_take;
    logic out_load;
    logic out_valid_reg, out_valid_next;
    logic out_level_reg;
    logic led_reg;

    assign in_take = in_valid && !in_stall;

    // Byte framing and note decode; state only advances on byte words.
    mppg_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take && action),
        .midi_byte (midi_byte),
        .msg       (msg)
    );

    // A tick word runs the counter sweep; bytes run a sweep only for notes.
    assign op = action ? msg.op : mppg_pkg::OP_TICK;

    assign cmd.start  = in_take && (op != mppg_pkg::OP_NONE);
    assign cmd.op     = op;
    assign cmd.period = msg.period;

    mppg_voice_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    // Sequencer: hold input while a word is in work, then load the result.
    always_comb
    begin
        state_next     = state_reg;
        out_load       = 1'b0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            mppg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = (op == mppg_pkg::OP_NONE) ? mppg_pkg::ST_RESULT
                                                           : mppg_pkg::ST_SWEEP;
                end
            end
            mppg_pkg::ST_SWEEP:
            begin
                if (status.done)
                begin
                    state_next = mppg_pkg::ST_RESULT;
                end
            end
            mppg_pkg::ST_RESULT:
            begin
                // Load when the output register is empty or being drained.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mppg_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mppg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg <= status.pin_level;
            led_reg       <= status.lamp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign led       = led_reg;

endmodule

/* hdl/mppg_checker.sv */
// Port-level checker of the pulse generator core and its bind.
`timescale 1ns / 1ps
`include "midi_polyphonic_pulse_generator_core_defines.svh"

module mppg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       out_level,
    input logic       led
);

    // Stalled result word holds.
    `MPPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `MPPG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_level) && $stable(led))
    // One word in work at a time: input closes right after acceptance.
    `MPPG_ASSERT_NEXT(a_one_in_work, in_valid && !in_stall, in_stall)
    // A presented result word carries known levels.
    `MPPG_ASSERT_NOW(a_out_known, out_valid, !$isunknown({out_level, led}))

endmodule

bind midi_polyphonic_pulse_generator_core mppg_checker u_mppg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level),
    .led       (led)
);

/* tb/tb.sv */
// Self-checking testbench for the MIDI polyphonic pulse generator core.
`timescale 1ns / 1ps

module tb;

    import mppg_pkg::*;

    // Meaning of the action field of an input word.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    localparam int WORD_TARGET  = 1950;
    localparam int SQUEEZE_AT   = 500;   // results between receiver hold-offs
    localparam int SQUEEZE_LEN  = 300;   // cycles of one long hold-off
    localparam int DRAIN_CYCLES = 4 * (VOICES + 3);
    localparam int IDLE_LIMIT   = 5000;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } midi_word_t;

    // What the block should show after one word: pin level and lamp.
    typedef struct packed {
        logic pin;
        logic lamp;
    } level_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       action    = ACT_TICK;
    logic [7:0] midi_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       out_level;
    logic       led;

    midi_polyphonic_pulse_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .midi_byte (midi_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_level (out_level),
        .led       (led)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: framing, four voices, shared pin and lamp.
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] note_period [NOTE_COUNT];  // period for every raw note byte
    int                  frame_pos   = 0;
    logic [7:0]          status_held = 8'd0;
    logic [7:0]          note_held   = 8'd0;
    logic [COUNT_W-1:0]  v_count  [VOICES] = '{default: '0};
    logic [PERIOD_W-1:0] v_period [VOICES] = '{default: '0};
    logic                v_active [VOICES] = '{default: 1'b0};
    logic                pin_now  = 1'b1;
    logic                lamp_now = 1'b0;

    midi_word_t word_feed [$];    // words still to be offered
    level_t     due_levels [$];   // predicted pin/lamp, oldest first
    int         total_words;

    // Coverage counters for the closing summary.
    int ticks_seen    = 0;
    int bytes_seen    = 0;
    int notes_started = 0;
    int notes_dropped = 0;
    int releases      = 0;
    int pulse_results = 0;
    int mismatches    = 0;

    logic [7:0] one_byte_codes [7] = '{SB_TUNE_REQ, SB_CLOCK, SB_START, SB_CONTINUE,
                                      SB_STOP, SB_SENSE, SB_RESET};

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Message length in bytes, fixed by the first byte of the frame.
    function automatic int frame_bytes(input logic [7:0] first);
        int len;
        len = 3;
        case (first[7:4])
            HI_PROG, HI_PRESSURE: len = 2;
            default: ;
        endcase
        case (first)
            SB_TIME_CODE, SB_SONG_SEL: len = 2;
            SB_TUNE_REQ, SB_CLOCK, SB_START, SB_CONTINUE,
            SB_STOP, SB_SENSE, SB_RESET: len = 1;
            default: ;
        endcase
        return len;
    endfunction

    // Advance the predictor by one accepted word and return the level it leaves.
    function automatic level_t apply_word(input logic act, input logic [7:0] data);
        level_t              r;
        logic [3:0]          kind;
        logic [PERIOD_W-1:0] p;
        bit                  placed;
        if (act == ACT_BYTE)
        begin
            bytes_seen++;
            if (frame_pos == 0)
            begin
                status_held = data;
            end
            else if (frame_pos == 1)
            begin
                note_held = data;
            end
            frame_pos++;
            if (frame_pos >= frame_bytes(status_held))
            begin
                // Frame complete: the last byte is the velocity for note messages.
                frame_pos = 0;
                kind = status_held[7:4];
                if (kind == HI_NOTE_ON || kind == HI_NOTE_OFF)
                begin
                    p = note_period[note_held];
                    if (kind == HI_NOTE_OFF || data == 8'd0)
                    begin
                        // Release every voice with this period, idle ones too.
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (v_period[i] == p)
                            begin
                                v_active[i] = 1'b0;
                                lamp_now = 1'b0;
                                releases++;
                            end
                        end
                    end
                    else
                    begin
                        placed = 1'b0;
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (!placed && !v_active[i])
                            begin
                                v_period[i] = p;
                                v_active[i] = 1'b1;
                                v_count[i]  = '0;
                                lamp_now    = 1'b1;
                                placed      = 1'b1;
                            end
                        end
                        if (placed)
                        begin
                            notes_started++;
                        end
                        else
                        begin
                            notes_dropped++;
                        end
                    end
                end
            end
        end
        else
        begin
            // Tick: voices in order, last write to the pin wins.
            ticks_seen++;
            for (int i = 0; i < VOICES; i++)
            begin
                if (v_count[i] == COUNT_W'(v_period[i]) && v_active[i])
                begin
                    pin_now = 1'b0;
                end
                if (17'(v_count[i]) == 17'(v_period[i]) + 17'd1)
                begin
                    pin_now = 1'b1;
                    v_count[i] = '0;
                end
                v_count[i] = v_count[i] + 1'b1;
            end
        end
        r.pin  = pin_now;
        r.lamp = lamp_now;
        return r;
    endfunction

    // Random idle length: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic feed(input logic act, input logic [7:0] data);
        midi_word_t w;
        w.act  = act;
        w.data = data;
        word_feed.push_back(w);
    endtask

    task automatic feed_msg(input logic [7:0] st, input logic [7:0] note, input logic [7:0] vel);
        feed(ACT_BYTE, st);
        feed(ACT_BYTE, note);
        feed(ACT_BYTE, vel);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words from the feed queue, predict on each acceptance.
    // ------------------------------------------------------------------
    int         gap_left    = 0;
    int         in_calm     = 0;
    int         words_taken = 0;
    midi_word_t next_word;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due_levels.push_back(apply_word(action, midi_byte));
                words_taken <= words_taken + 1;
            end
            // Hold the word while stalled; otherwise idle or present the next one.
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (word_feed.size() > 0)
                begin
                    next_word = word_feed.pop_front();
                    in_valid  <= 1'b1;
                    action    <= next_word.act;
                    midi_byte <= next_word.data;
                    if (in_calm > 0)
                    begin
                        in_calm  <= in_calm - 1;
                        gap_left <= 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 99) < 3)
                        begin
                            in_calm <= $urandom_range(40, 150);
                        end
                        gap_left <= pause_len();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction, drive stall.
    // ------------------------------------------------------------------
    int     hold_left    = 0;
    int     out_calm     = 0;
    int     squeezes     = 0;
    int     results_seen = 0;
    int     stall_len;
    level_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_levels.size() == 0)
                begin
                    report_mismatch("result word with no prediction waiting");
                end
                else
                begin
                    want = due_levels.pop_front();
                    if (out_level !== want.pin)
                    begin
                        report_mismatch($sformatf("out_level %b, predicted %b (result %0d)",
                                                  out_level, want.pin, results_seen));
                    end
                    if (led !== want.lamp)
                    begin
                        report_mismatch($sformatf("led %b, predicted %b (result %0d)",
                                                  led, want.lamp, results_seen));
                    end
                end
                if (out_level == 1'b0)
                begin
                    pulse_results <= pulse_results + 1;
                end
                results_seen <= results_seen + 1;
            end

            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (squeezes < 2 && results_seen >= SQUEEZE_AT * (squeezes + 1))
            begin
                // Long hold-off: the block fills and must stall its input.
                out_stall <= 1'b1;
                hold_left <= SQUEEZE_LEN;
                squeezes  <= squeezes + 1;
            end
            else if (out_calm > 0)
            begin
                out_stall <= 1'b0;
                out_calm  <= out_calm - 1;
            end
            else
            begin
                stall_len = pause_len();
                if ($urandom_range(0, 99) < 3)
                begin
                    out_calm <= $urandom_range(40, 150);
                end
                out_stall <= (stall_len != 0);
                hold_left <= (stall_len > 0) ? stall_len - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either side for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d predictions open",
                         IDLE_LIMIT, due_levels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        longint unsigned fx;
        int              n;
        int              pick;
        int              idx;
        logic [7:0]      status;
        logic [7:0]      note;
        logic [7:0]      held_notes [$];

        // Build the note-to-period table: fold into range, then Q32.32 power.
        for (int b = 0; b < NOTE_COUNT; b++)
        begin
            n = b;
            while (n > NOTE_MAX)
            begin
                n = n - OCTAVE;
            end
            while (n < NOTE_MIN)
            begin
                n = n + OCTAVE;
            end
            if (n >= NOTE_TOP)
            begin
                note_period[b] = PERIOD_W'(TOP_BASE - n);
            end
            else
            begin
                fx = BASE_PERIOD << 32;
                for (int k = 0; k < NOTE_TOP - n; k++)
                begin
                    fx = fx * RATIO_NUM / RATIO_DEN;
                end
                note_period[b] = PERIOD_W'(fx >> 32);
            end
        end

        // Directed part. A tick straight out of reset hits the idle voices.
        feed(ACT_TICK, 8'hFF);
        // Fill all four voices: lowest note, top byte, top folded note, first fixed note.
        feed_msg({HI_NOTE_ON, 4'h0}, 8'h00, 8'h7F);
        feed_msg({HI_NOTE_ON, 4'hF}, 8'hFF, 8'hFF);
        feed_msg({HI_NOTE_ON, 4'h5}, 8'(NOTE_MAX), 8'h01);
        feed_msg({HI_NOTE_ON, 4'h0}, 8'(NOTE_TOP), 8'h40);
        // Every voice busy: this note on is dropped.
        feed_msg({HI_NOTE_ON, 4'h3}, 8'd60, 8'h64);
        // Note on with zero velocity acts as note off.
        feed_msg({HI_NOTE_ON, 4'h1}, 8'(NOTE_MAX), 8'h00);
        // Note off message, raw byte that folds onto a held voice.
        feed_msg({HI_NOTE_OFF, 4'h0}, 8'hFF, 8'h40);
        // Two-byte and one-byte frames, then a data byte opening a frame.
        feed(ACT_BYTE, {HI_PROG, 4'h2});
        feed(ACT_BYTE, 8'h05);
        feed(ACT_BYTE, SB_CLOCK);
        feed(ACT_BYTE, 8'h3C);
        feed(ACT_BYTE, 8'h3C);
        feed(ACT_BYTE, 8'h40);

        // Random part: mostly well-formed note traffic between tick bursts.
        while (word_feed.size() < WORD_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Bias toward high notes so that pulses come within short bursts.
                idx = $urandom_range(0, 9);
                if (idx < 7)
                begin
                    note = 8'($urandom_range(73, 127));
                end
                else if (idx < 9)
                begin
                    note = 8'($urandom);
                end
                else
                begin
                    note = 8'($urandom_range(0, NOTE_MIN - 1));
                end
                feed_msg({HI_NOTE_ON, 4'($urandom)}, note, 8'($urandom_range(1, 255)));
                held_notes.push_back(note);
                if (held_notes.size() > 8)
                begin
                    held_notes.delete(0);
                end
            end
            else if (pick < 45)
            begin
                if (held_notes.size() > 0 && $urandom_range(0, 4) != 0)
                begin
                    idx  = $urandom_range(0, held_notes.size() - 1);
                    note = held_notes[idx];
                    held_notes.delete(idx);
                end
                else
                begin
                    note = 8'($urandom);
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    feed_msg({HI_NOTE_OFF, 4'($urandom)}, note, 8'($urandom));
                end
                else
                begin
                    feed_msg({HI_NOTE_ON, 4'($urandom)}, note, 8'd0);
                end
            end
            else if (pick < 53)
            begin
                // Other messages, framed by their own length.
                if ($urandom_range(0, 2) == 0)
                begin
                    status = one_byte_codes[$urandom_range(0, 6)];
                end
                else
                begin
                    status = 8'($urandom_range(128, 255));
                end
                feed(ACT_BYTE, status);
                repeat (frame_bytes(status) - 1)
                begin
                    feed(ACT_BYTE, 8'($urandom));
                end
            end
            else if (pick < 57)
            begin
                // Stray byte: breaks the framing of what follows.
                feed(ACT_BYTE, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 40))
                begin
                    feed(ACT_TICK, 8'($urandom));
                end
            end
        end
        total_words = word_feed.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every result to come out.
        while (words_taken < total_words)
        begin
            @(posedge clk);
        end
        while (due_levels.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d words: %0d ticks, %0d MIDI bytes; %0d notes placed, %0d dropped",
                 total_words, ticks_seen, bytes_seen, notes_started, notes_dropped);
        $display("%0d voice releases, %0d results with the pin low, %0d long hold-offs",
                 releases, pulse_results, squeezes);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/mppg_pkg.sv
hdl/mppg_framer.sv
hdl/mppg_voice_engine.sv
hdl/midi_polyphonic_pulse_generator_core.sv
hdl/mppg_checker.sv
tb/tb.sv
